/* design/ymps_pkg.sv */
package ymps_pkg;

    localparam int SHORT_PACKET_BYTES = 128;
    localparam int LONG_PACKET_BYTES  = 1024;
    localparam int MAX_TIMEOUTS       = 2;
    localparam int QUEUE_DEPTH        = 2;
    localparam int TCNT_W             = 2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] CRC_POLY      = 16'h1021;

    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;

    // raw item kind codes on the input channel
    typedef enum logic [2:0] {
        KIND_LOAD  = 3'd0,
        KIND_START = 3'd1,
        KIND_SLOT  = 3'd2,
        KIND_REPLY = 3'd3,
        KIND_TICK  = 3'd4
    } t_kind;

    // classified operation handed to the back end
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_START,
        CMD_SLOT,
        CMD_REPLY,
        CMD_TICK
    } t_cmd_op;

    typedef enum logic [1:0] {
        RPL_ACK,
        RPL_NAK,
        RPL_OTHER
    } t_reply;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SENDING = 3'd1,
        PH_AWAIT   = 3'd2,
        PH_ACKED   = 3'd3,
        PH_BAD     = 3'd4,
        PH_TIMEOUT = 3'd5
    } t_phase;

    // where the emitted byte comes from
    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_FIXED,
        SEL_PAYLOAD,
        SEL_PAD,
        SEL_CRC_HI,
        SEL_CRC_LO
    } t_byte_sel;

    typedef struct packed {
        t_cmd_op     op;
        t_reply      reply;
        logic [7:0]  data;
        logic [15:0] block;
    } t_cmd;

    typedef struct packed {
        t_byte_sel  sel;
        logic [7:0] fixed_byte;
        logic       crc_clear;
        logic       last;
        t_phase     status;
    } t_tok;

    // CRC-16/XMODEM, one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* design/ymps_in_if.sv */
interface ymps_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] block_number;

    modport source (output valid, output kind, output data_byte, output block_number,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input block_number,
                    output ready);
endinterface

/* design/ymps_out_if.sv */
interface ymps_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] status;
    logic       frame_last;

    modport source (output valid, output tx_valid, output tx_byte, output status,
                    output frame_last, input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input status,
                    input frame_last, output ready);
endinterface

/* design/ymps_front.sv */
module ymps_front (
    ymps_in_if.sink        i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output ymps_pkg::t_cmd o_cmd
);

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    // classify the word
    always_comb begin
        o_cmd.data  = i_in.data_byte;
        o_cmd.block = i_in.block_number;
        case (i_in.kind)
            ymps_pkg::KIND_LOAD:  o_cmd.op = ymps_pkg::CMD_LOAD;
            ymps_pkg::KIND_START: o_cmd.op = ymps_pkg::CMD_START;
            ymps_pkg::KIND_SLOT:  o_cmd.op = ymps_pkg::CMD_SLOT;
            ymps_pkg::KIND_REPLY: o_cmd.op = ymps_pkg::CMD_REPLY;
            ymps_pkg::KIND_TICK:  o_cmd.op = ymps_pkg::CMD_TICK;
            default:              o_cmd.op = ymps_pkg::CMD_NONE;
        endcase
        if (i_in.data_byte == ymps_pkg::BYTE_ACK) begin
            o_cmd.reply = ymps_pkg::RPL_ACK;
        end else if (i_in.data_byte == ymps_pkg::BYTE_NAK) begin
            o_cmd.reply = ymps_pkg::RPL_NAK;
        end else begin
            o_cmd.reply = ymps_pkg::RPL_OTHER;
        end
    end

endmodule

/* design/ymps_queue.sv */
module ymps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ymps_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output ymps_pkg::t_cmd o_cmd
);

    localparam int PTR_W = (ymps_pkg::QUEUE_DEPTH > 1) ? $clog2(ymps_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ymps_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ymps_pkg::QUEUE_DEPTH - 1);

    ymps_pkg::t_cmd   r_entry [ymps_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(ymps_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* design/ymps_ctrl.sv */
module ymps_ctrl #(
    parameter int SHORT_PACKET_BYTES = ymps_pkg::SHORT_PACKET_BYTES,
    parameter int LONG_PACKET_BYTES  = ymps_pkg::LONG_PACKET_BYTES,
    parameter int MAX_TIMEOUTS       = ymps_pkg::MAX_TIMEOUTS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata,
    input  logic           i_q_valid,
    input  ymps_pkg::t_cmd i_cmd,
    output logic           o_q_pop,
    output logic           o_tok_valid,
    input  logic           i_tok_ready,
    output ymps_pkg::t_tok o_tok,
    output logic [7:0]     o_rd_data
);

    localparam int MAX_N  = (SHORT_PACKET_BYTES > LONG_PACKET_BYTES) ?
                            SHORT_PACKET_BYTES : LONG_PACKET_BYTES;
    localparam int POS_W  = $clog2(MAX_N + 5);
    localparam int LOAD_W = $clog2(LONG_PACKET_BYTES + 1);
    localparam int ADDR_W = $clog2(LONG_PACKET_BYTES);
    localparam int TW     = ymps_pkg::TCNT_W;

    logic [7:0]            r_store [LONG_PACKET_BYTES];
    logic [7:0]            r_rd_data;
    logic [15:0]           r_timeout_cfg;
    ymps_pkg::t_phase      r_phase, n_phase;
    logic [LOAD_W-1:0]     r_load_pos, n_load_pos;
    logic [POS_W-1:0]      r_send_pos, n_send_pos;
    logic [15:0]           r_block, n_block;
    logic [TW-1:0]         r_tcount, n_tcount;
    logic [15:0]           r_wait, n_wait;
    logic                  r_tok_valid;
    ymps_pkg::t_tok        r_tok, n_tok;

    logic                  a_fire;
    logic                  busy;
    logic                  store_we;
    logic [POS_W-1:0]      n_bytes;
    logic [POS_W-1:0]      crc_hi_pos;
    logic [POS_W-1:0]      pay_idx;
    logic [15:0]           wait_inc;
    logic                  wait_hit;
    logic [TW-1:0]         tcount_inc;
    logic                  frame_restart;
    logic                  slot_live;
    logic                  slot_last;

    assign a_fire      = i_q_valid && (!r_tok_valid || i_tok_ready);
    assign o_q_pop     = a_fire;
    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;
    assign o_rd_data   = r_rd_data;

    // shared decode of the current word against the state
    always_comb begin
        busy       = (r_phase == ymps_pkg::PH_SENDING) || (r_phase == ymps_pkg::PH_AWAIT);
        n_bytes    = (r_block == 16'd0) ? POS_W'(SHORT_PACKET_BYTES) : POS_W'(LONG_PACKET_BYTES);
        crc_hi_pos = n_bytes + POS_W'(3);
        pay_idx    = r_send_pos - POS_W'(3);
        wait_inc   = r_wait + 16'd1;
        wait_hit   = (wait_inc >= r_timeout_cfg);
        tcount_inc = r_tcount + TW'(1);
        slot_live  = (i_cmd.op == ymps_pkg::CMD_SLOT) && (r_phase == ymps_pkg::PH_SENDING);
        slot_last  = (r_send_pos > crc_hi_pos);
        frame_restart =
            ((i_cmd.op == ymps_pkg::CMD_START) && !busy) ||
            ((i_cmd.op == ymps_pkg::CMD_REPLY) && (r_phase == ymps_pkg::PH_AWAIT) &&
             (i_cmd.reply == ymps_pkg::RPL_NAK)) ||
            ((i_cmd.op == ymps_pkg::CMD_TICK) && (r_phase == ymps_pkg::PH_AWAIT) &&
             wait_hit && (tcount_inc < TW'(MAX_TIMEOUTS)));
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_load_pos = r_load_pos;
        n_send_pos = r_send_pos;
        n_block    = r_block;
        n_tcount   = r_tcount;
        n_wait     = r_wait;
        store_we   = 1'b0;
        if (a_fire) begin
            case (i_cmd.op)
                ymps_pkg::CMD_LOAD: begin
                    if (!busy && (r_load_pos < LOAD_W'(LONG_PACKET_BYTES))) begin
                        store_we   = 1'b1;
                        n_load_pos = r_load_pos + LOAD_W'(1);
                    end
                end
                ymps_pkg::CMD_START: begin
                    if (!busy) begin
                        n_block    = i_cmd.block;
                        n_load_pos = '0;
                        n_tcount   = '0;
                    end
                end
                ymps_pkg::CMD_SLOT: begin
                    if (slot_live) begin
                        if (slot_last) begin
                            n_phase = ymps_pkg::PH_AWAIT;
                            n_wait  = '0;
                        end else begin
                            n_send_pos = r_send_pos + POS_W'(1);
                        end
                    end
                end
                ymps_pkg::CMD_REPLY: begin
                    if (r_phase == ymps_pkg::PH_AWAIT) begin
                        case (i_cmd.reply)
                            ymps_pkg::RPL_ACK: n_phase = ymps_pkg::PH_ACKED;
                            ymps_pkg::RPL_NAK: n_phase = r_phase;
                            default:           n_phase = ymps_pkg::PH_BAD;
                        endcase
                    end
                end
                ymps_pkg::CMD_TICK: begin
                    if (r_phase == ymps_pkg::PH_AWAIT) begin
                        if (wait_hit) begin
                            n_wait   = '0;
                            n_tcount = tcount_inc;
                            if (tcount_inc >= TW'(MAX_TIMEOUTS)) begin
                                n_phase = ymps_pkg::PH_TIMEOUT;
                            end
                        end else begin
                            n_wait = wait_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (frame_restart) begin
                n_send_pos = '0;
                n_wait     = '0;
                n_phase    = ymps_pkg::PH_SENDING;
            end
        end
    end

    // token for the emit stage
    always_comb begin
        n_tok.sel        = ymps_pkg::SEL_NONE;
        n_tok.fixed_byte = 8'h00;
        n_tok.crc_clear  = frame_restart;
        n_tok.last       = 1'b0;
        n_tok.status     = n_phase;
        if (slot_live) begin
            if (r_send_pos == POS_W'(0)) begin
                n_tok.sel        = ymps_pkg::SEL_FIXED;
                n_tok.fixed_byte = (r_block == 16'd0) ? ymps_pkg::BYTE_SOH : ymps_pkg::BYTE_STX;
            end else if (r_send_pos == POS_W'(1)) begin
                n_tok.sel        = ymps_pkg::SEL_FIXED;
                n_tok.fixed_byte = r_block[7:0];
            end else if (r_send_pos == POS_W'(2)) begin
                n_tok.sel        = ymps_pkg::SEL_FIXED;
                n_tok.fixed_byte = ~r_block[7:0];
            end else if (r_send_pos < crc_hi_pos) begin
                n_tok.sel = (pay_idx < POS_W'(LONG_PACKET_BYTES)) ?
                            ymps_pkg::SEL_PAYLOAD : ymps_pkg::SEL_PAD;
            end else if (r_send_pos == crc_hi_pos) begin
                n_tok.sel = ymps_pkg::SEL_CRC_HI;
            end else begin
                n_tok.sel  = ymps_pkg::SEL_CRC_LO;
                n_tok.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_cfg <= ymps_pkg::TIMEOUT_RESET;
            r_phase       <= ymps_pkg::PH_IDLE;
            r_load_pos    <= '0;
            r_send_pos    <= '0;
            r_block       <= '0;
            r_tcount      <= '0;
            r_wait        <= '0;
            r_tok_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout_cfg <= i_cfg_wdata;
            end
            r_phase    <= n_phase;
            r_load_pos <= n_load_pos;
            r_send_pos <= n_send_pos;
            r_block    <= n_block;
            r_tcount   <= n_tcount;
            r_wait     <= n_wait;
            if (a_fire) begin
                r_tok_valid <= 1'b1;
            end else if (i_tok_ready) begin
                r_tok_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_tok <= n_tok;
        end
    end

    // payload store: one write port for loads, one registered read port
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_load_pos[ADDR_W-1:0]] <= i_cmd.data;
        end
        if (a_fire) begin
            r_rd_data <= r_store[pay_idx[ADDR_W-1:0]];
        end
    end

endmodule

/* design/ymps_emit.sv */
module ymps_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_tok_valid,
    output logic           o_tok_ready,
    input  ymps_pkg::t_tok i_tok,
    input  logic [7:0]     i_rd_data,
    ymps_out_if.source     o_out
);

    logic        r_out_valid;
    logic        r_tx_valid, n_tx_valid;
    logic [7:0]  r_tx_byte, n_tx_byte;
    logic [2:0]  r_status;
    logic        r_last;
    logic [15:0] r_crc, n_crc;
    logic        b_fire;

    assign b_fire      = i_tok_valid && (!r_out_valid || o_out.ready);
    assign o_tok_ready = !r_out_valid || o_out.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.tx_valid   = r_tx_valid;
    assign o_out.tx_byte    = r_tx_byte;
    assign o_out.status     = r_status;
    assign o_out.frame_last = r_last;

    always_comb begin
        n_tx_valid = 1'b1;
        n_tx_byte  = 8'h00;
        n_crc      = i_tok.crc_clear ? 16'h0000 : r_crc;
        case (i_tok.sel)
            ymps_pkg::SEL_FIXED:   n_tx_byte = i_tok.fixed_byte;
            ymps_pkg::SEL_PAYLOAD: begin
                n_tx_byte = i_rd_data;
                n_crc     = ymps_pkg::crc16_byte(r_crc, i_rd_data);
            end
            ymps_pkg::SEL_PAD:     n_crc = ymps_pkg::crc16_byte(r_crc, 8'h00);
            ymps_pkg::SEL_CRC_HI:  n_tx_byte = r_crc[15:8];
            ymps_pkg::SEL_CRC_LO:  n_tx_byte = r_crc[7:0];
            default:               n_tx_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_crc       <= '0;
        end else begin
            if (b_fire) begin
                r_out_valid <= 1'b1;
                r_crc       <= n_crc;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_tx_valid <= n_tx_valid;
            r_tx_byte  <= n_tx_byte;
            r_status   <= i_tok.status;
            r_last     <= i_tok.last;
        end
    end

endmodule

/* design/ymodem_packet_sender.sv */
// YMODEM packet sender, CRC-16/XMODEM framing. Every input word (load, start,
// transmit slot, reply byte, tick) yields exactly one output word carrying the
// framed byte if any, the phase after the word, and a flag on the final CRC byte.
// Sustained rate is one word per clock on both channels while the output side
// accepts; a word passes the registered input queue, control stage with the
// payload store read and emit stage with the running CRC. The input channel
// stays ready while the two-entry queue has room, so a stalled output side
// only backs up once the queue and both stages are full. The payload store is a
// LONG_PACKET_BYTES x 8 memory with one write port for loads and one registered
// read port for payload bytes; it is not cleared at reset and an entry that
// was never loaded sends arbitrary data. Write reply_timeout_ticks (reset 1000)
// only while the block is idle.
module ymodem_packet_sender #(
    parameter int SHORT_PACKET_BYTES = ymps_pkg::SHORT_PACKET_BYTES,
    parameter int LONG_PACKET_BYTES  = ymps_pkg::LONG_PACKET_BYTES,
    parameter int MAX_TIMEOUTS       = ymps_pkg::MAX_TIMEOUTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    ymps_in_if.sink     i_in,
    ymps_out_if.source  o_out
);

    // front to queue
    logic           push;
    logic           q_full;
    ymps_pkg::t_cmd push_cmd;

    // queue to control stage
    logic           q_valid;
    logic           q_pop;
    ymps_pkg::t_cmd q_cmd;

    // control stage to emit stage
    logic           tok_valid;
    logic           tok_ready;
    ymps_pkg::t_tok tok;
    logic [7:0]     rd_data;

    // decode the kind and reply class of each word
    ymps_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // decouple acceptance from execution
    ymps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    // advance the phase, counters and store; pick the byte source
    ymps_ctrl #(
        .SHORT_PACKET_BYTES (SHORT_PACKET_BYTES),
        .LONG_PACKET_BYTES  (LONG_PACKET_BYTES),
        .MAX_TIMEOUTS       (MAX_TIMEOUTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_q_pop     (q_pop),
        .o_tok_valid (tok_valid),
        .i_tok_ready (tok_ready),
        .o_tok       (tok),
        .o_rd_data   (rd_data)
    );

    // form the byte, accumulate the CRC and hold the output word
    ymps_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .o_tok_ready (tok_ready),
        .i_tok       (tok),
        .i_rd_data   (rd_data),
        .o_out       (o_out)
    );

endmodule

/* tb/sv/tb_ymodem_packet_sender.sv */
`timescale 1ns / 1ps

module tb_ymodem_packet_sender;
    import ymps_pkg::*;

    // kinds the block ignores; the field is three bits wide, so drive them too
    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

    localparam int N_DIRECTED    = 25;
    localparam int RANDOM_PHASES = 2;
    localparam int PROBE_SLOTS   = 8;       // long-packet header plus a few payload bytes
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int SETTLE_CYCLES = 12;      // three-stage pipe plus margin
    localparam int LIMIT_CYCLES  = 3000000;
    localparam int PRINT_CAP     = 50;

    // one output word as seen on the result channel
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        t_phase     status;
        logic       frame_last;
    } t_tx_word;

    // one directed row: repeat the input word reps times, check against typed
    // word only where it is marked
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [15:0] blk;
        logic [10:0] reps;
        logic        typed;
        t_tx_word    want;
    } t_step_row;

    localparam t_tx_word NO_WORD = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    ymps_in_if  in_ch ();
    ymps_out_if out_ch ();

    ymodem_packet_sender DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the sender, updated per accepted word
    // ------------------------------------------------------------------
    logic [15:0] m_timeout_reg;
    logic [7:0]  m_store [LONG_PACKET_BYTES];
    int unsigned m_load_pos;
    int unsigned m_send_pos;
    int unsigned m_written_upto;    // entries [0, m_written_upto) hold known data
    logic [15:0] m_crc;
    logic [15:0] m_block;
    logic [15:0] m_wait;
    logic [1:0]  m_timeouts;
    t_phase      m_phase;

    t_tx_word expected_tx_words [$];

    int unsigned words_in;
    int unsigned words_out;
    int unsigned mismatches;
    int unsigned frames_sent;
    int unsigned acks_seen;
    int unsigned naks_seen;
    int unsigned bad_seen;
    int unsigned timeouts_seen;
    int unsigned cycle_count;

    int  send_calm;
    int  sink_gap;
    int  sink_calm;
    bit  hold_request;
    logic hold_off;

    t_step_row directed_rows [N_DIRECTED];
    t_tx_word  got_word;
    t_tx_word  want_word;

    // CRC-16/XMODEM, one byte, bit-serial form
    function automatic logic [15:0] crc_xmodem_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0};
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic void rewind_frame();
        m_send_pos = 0;
        m_crc      = '0;
        m_wait     = '0;
        m_phase    = PH_SENDING;
    endfunction

    // Advance the predicted sender by one input word; return the word it emits.
    function automatic t_tx_word advance_sender(input logic [2:0] kind, input logic [7:0] data,
                                                input logic [15:0] blk);
        t_tx_word    w;
        int unsigned n;
        int unsigned p;
        logic        busy;
        w    = '0;
        busy = (m_phase == PH_SENDING) || (m_phase == PH_AWAIT);
        case (kind)
            KIND_LOAD: begin
                if (!busy && m_load_pos < LONG_PACKET_BYTES) begin
                    m_store[m_load_pos] = data;
                    m_load_pos++;
                    if (m_load_pos > m_written_upto) m_written_upto = m_load_pos;
                end
            end
            KIND_START: begin
                if (!busy) begin
                    m_block    = blk;
                    m_load_pos = 0;
                    m_timeouts = '0;
                    rewind_frame();
                end
            end
            KIND_SLOT: begin
                if (m_phase == PH_SENDING) begin
                    n = (m_block == 16'd0) ? SHORT_PACKET_BYTES : LONG_PACKET_BYTES;
                    p = m_send_pos;
                    w.tx_valid = 1'b1;
                    if (p == 0) begin
                        w.tx_byte = (m_block == 16'd0) ? BYTE_SOH : BYTE_STX;
                    end else if (p == 1) begin
                        w.tx_byte = m_block[7:0];
                    end else if (p == 2) begin
                        w.tx_byte = ~m_block[7:0];
                    end else if (p < 3 + n) begin
                        w.tx_byte = m_store[p - 3];
                        m_crc     = crc_xmodem_step(m_crc, w.tx_byte);
                    end else if (p == 3 + n) begin
                        w.tx_byte = m_crc[15:8];
                    end else begin
                        w.tx_byte    = m_crc[7:0];
                        w.frame_last = 1'b1;
                    end
                    if (w.frame_last) begin
                        m_phase = PH_AWAIT;
                        m_wait  = '0;
                        frames_sent++;
                    end else begin
                        m_send_pos = p + 1;
                    end
                end
            end
            KIND_REPLY: begin
                if (m_phase == PH_AWAIT) begin
                    if (data == BYTE_ACK) begin
                        m_phase = PH_ACKED;
                        acks_seen++;
                    end else if (data == BYTE_NAK) begin
                        rewind_frame();
                        naks_seen++;
                    end else begin
                        m_phase = PH_BAD;
                        bad_seen++;
                    end
                end
            end
            KIND_TICK: begin
                if (m_phase == PH_AWAIT) begin
                    m_wait = m_wait + 16'd1;
                    if (m_wait >= m_timeout_reg) begin
                        m_wait     = '0;
                        m_timeouts = m_timeouts + 2'd1;
                        timeouts_seen++;
                        if (m_timeouts >= MAX_TIMEOUTS) m_phase = PH_TIMEOUT;
                        else rewind_frame();
                    end
                end
            end
            default: begin
            end
        endcase
        w.status = m_phase;
        return w;
    endfunction

    // Most gaps are a few cycles; now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // Pick one of four kinds, or one of the unused ones.
    function automatic logic [2:0] noise_kind(input logic [2:0] k0, input logic [2:0] k1,
                                              input logic [2:0] k2, input logic [2:0] k3);
        case ($urandom_range(0, 5))
            0: return k0;
            1: return k1;
            2: return k2;
            3: return k3;
            default: return 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        endcase
    endfunction

    // Payload bytes with the extremes weighted up.
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("mismatch at output word %0d: %s got 0x%0h want 0x%0h",
                     words_out, what, got, want);
        end
    endtask

    // Offer one word, hold it until accepted, predict it, then maybe idle.
    task automatic put_word(input logic [2:0] kind, input logic [7:0] data,
                            input logic [15:0] blk, input bit typed, input t_tx_word typed_word);
        bit       taken;
        int       gap;
        t_tx_word predicted;
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.data_byte    <= data;
        in_ch.block_number <= blk;
        taken = 1'b0;
        // sample ready mid-cycle; the word goes in at the following edge
        while (!taken) begin
            @(negedge i_clk);
            taken = (in_ch.ready === 1'b1);
            @(posedge i_clk);
        end
        words_in++;
        predicted = advance_sender(kind, data, blk);
        expected_tx_words.push_back(typed ? typed_word : predicted);
        gap = 0;
        if (send_calm > 0) begin
            send_calm--;
        end else begin
            case ($urandom_range(0, 49))
                0:                   send_calm = $urandom_range(40, 160);
                1, 2, 3, 4, 5, 6, 7,
                8, 9, 10:            gap = gap_length();
                default:             gap = 0;
            endcase
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every predicted word has come back.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (expected_tx_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout_reg(input logic [15:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        m_timeout_reg  = value;
    endtask

    // Answer a finished frame: a few harmless ticks, then ACK, NAK, a bad byte,
    // or ticks until the timeout fires.
    task automatic answer_frame(inout int naks_left, input bit allow_timeout);
        int         pre;
        int         pick;
        logic [7:0] bad;
        if (m_timeout_reg == 16'd0) pre = 0;
        else pre = $urandom_range(0, (m_timeout_reg - 1 < 4) ? m_timeout_reg - 1 : 4);
        repeat (pre) put_word(KIND_TICK, 8'($urandom), 16'($urandom), 1'b0, NO_WORD);
        pick = $urandom_range(0, 99);
        if (pick < 15 && naks_left > 0) begin
            naks_left--;
            put_word(KIND_REPLY, BYTE_NAK, 16'($urandom), 1'b0, NO_WORD);
        end else if (pick < 35 && allow_timeout) begin
            while (m_phase == PH_AWAIT) begin
                put_word(KIND_TICK, 8'($urandom), 16'($urandom), 1'b0, NO_WORD);
            end
        end else if (pick < 55) begin
            bad = payload_byte();
            while (bad == BYTE_ACK || bad == BYTE_NAK) bad = 8'($urandom);
            put_word(KIND_REPLY, bad, 16'($urandom), 1'b0, NO_WORD);
        end else begin
            put_word(KIND_REPLY, BYTE_ACK, 16'($urandom), 1'b0, NO_WORD);
        end
    endtask

    // One short packet exchange: load, start, send the frame with noise mixed
    // in, answer it until the block leaves the busy phases.
    task automatic run_exchange();
        int nloads;
        int naks_left;
        bit allow_timeout;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: nloads = $urandom_range(0, 8);
            7, 8:                nloads = $urandom_range(9, SHORT_PACKET_BYTES);
            default:             nloads = $urandom_range(SHORT_PACKET_BYTES + 1,
                                                         SHORT_PACKET_BYTES + 40);
        endcase
        // never let a frame read a store entry that was never written
        if (m_written_upto < SHORT_PACKET_BYTES && m_load_pos + nloads < SHORT_PACKET_BYTES)
            nloads = SHORT_PACKET_BYTES - m_load_pos;
        repeat (nloads) put_word(KIND_LOAD, payload_byte(), 16'($urandom), 1'b0, NO_WORD);

        put_word(KIND_START, 8'($urandom), 16'h0000, 1'b0, NO_WORD);
        if ($urandom_range(0, 5) == 0) wait_for_results();

        naks_left     = 1;
        allow_timeout = (m_timeout_reg <= 16'd20);
        while (m_phase == PH_SENDING || m_phase == PH_AWAIT) begin
            if ($urandom_range(0, 19) == 0) begin
                // busy-phase noise: all of it is dropped by the block
                if (m_phase == PH_SENDING) begin
                    put_word(noise_kind(KIND_LOAD, KIND_START, KIND_REPLY, KIND_TICK),
                             8'($urandom), 16'($urandom), 1'b0, NO_WORD);
                end else begin
                    put_word(noise_kind(KIND_LOAD, KIND_START, KIND_SLOT, KIND_SLOT),
                             8'($urandom), 16'($urandom), 1'b0, NO_WORD);
                end
            end else if (m_phase == PH_SENDING) begin
                put_word(KIND_SLOT, 8'($urandom), 16'($urandom), 1'b0, NO_WORD);
            end else begin
                answer_frame(naks_left, allow_timeout);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, a long hold-off once, check each word
    // ------------------------------------------------------------------
    initial begin
        hold_off <= 1'b0;
        wait (hold_request);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        out_ch.ready <= 1'b0;
        sink_gap  = 0;
        sink_calm = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                out_ch.ready <= 1'b0;
            end else if (sink_calm > 0) begin
                sink_calm--;
                out_ch.ready <= 1'b1;
            end else begin
                case ($urandom_range(0, 49))
                    0: begin
                        sink_calm = $urandom_range(40, 160);
                        out_ch.ready <= 1'b1;
                    end
                    1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
                        sink_gap = gap_length() - 1;
                        out_ch.ready <= 1'b0;
                    end
                    default: out_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // Compare mid-cycle; a word seen here is taken at the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            words_out++;
            got_word.tx_valid   = out_ch.tx_valid;
            got_word.tx_byte    = out_ch.tx_byte;
            got_word.status     = t_phase'(out_ch.status);
            got_word.frame_last = out_ch.frame_last;
            if (expected_tx_words.size() == 0) begin
                report_mismatch("word with nothing pending", 32'(got_word), 32'd0);
            end else begin
                want_word = expected_tx_words.pop_front();
                if (got_word.tx_valid !== want_word.tx_valid)
                    report_mismatch("tx_valid", 32'(got_word.tx_valid),
                                    32'(want_word.tx_valid));
                if (got_word.tx_byte !== want_word.tx_byte)
                    report_mismatch("tx_byte", 32'(got_word.tx_byte), 32'(want_word.tx_byte));
                if (got_word.status !== want_word.status)
                    report_mismatch("status", 32'(got_word.status), 32'(want_word.status));
                if (got_word.frame_last !== want_word.frame_last)
                    report_mismatch("frame_last", 32'(got_word.frame_last),
                                    32'(want_word.frame_last));
            end
        end
    end

    // Watchdog: end the run if it hangs anywhere.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words still pending",
                 cycle_count, expected_tx_words.size());
        $display("[ymodem_packet_sender] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] phase_timeout [RANDOM_PHASES];
        logic [15:0] probe_blk;

        // known values on every input from time zero
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.kind         <= KIND_LOAD;
        in_ch.data_byte    <= '0;
        in_ch.block_number <= '0;

        // predictor reset
        m_timeout_reg  = TIMEOUT_RESET;
        m_load_pos     = 0;
        m_send_pos     = 0;
        m_written_upto = 0;
        m_crc          = '0;
        m_block        = '0;
        m_wait         = '0;
        m_timeouts     = '0;
        m_phase        = PH_IDLE;
        words_in       = 0;
        words_out      = 0;
        mismatches     = 0;
        frames_sent    = 0;
        acks_seen      = 0;
        naks_seen      = 0;
        bad_seen       = 0;
        timeouts_seen  = 0;
        send_calm      = 0;
        hold_request   = 1'b0;

        // Directed rows. After reset: idle-phase words; load a short payload
        // (0x00, 0xFF, then filler), send block 0 with the header bytes typed
        // in, then poke the block while it waits, answer with a bad reply and poke it again.
        directed_rows = '{
            '{KIND_SLOT,      8'h00, 16'h0000, 11'd1,   1'b1, '{1'b0, 8'h00, PH_IDLE, 1'b0}},
            '{KIND_REPLY,     BYTE_ACK, 16'hFFFF, 11'd1, 1'b1, '{1'b0, 8'h00, PH_IDLE, 1'b0}},
            '{KIND_TICK,      8'hFF, 16'hFFFF, 11'd1,   1'b1, '{1'b0, 8'h00, PH_IDLE, 1'b0}},
            '{KIND_UNUSED_LO, 8'hFF, 16'hFFFF, 11'd1,   1'b1, '{1'b0, 8'h00, PH_IDLE, 1'b0}},
            '{KIND_UNUSED_HI, 8'h00, 16'h0000, 11'd1,   1'b1, '{1'b0, 8'h00, PH_IDLE, 1'b0}},
            '{KIND_LOAD,      8'h00, 16'h0000, 11'd1,   1'b1, '{1'b0, 8'h00, PH_IDLE, 1'b0}},
            '{KIND_LOAD,      8'hFF, 16'hFFFF, 11'd1,   1'b1, '{1'b0, 8'h00, PH_IDLE, 1'b0}},
            '{KIND_LOAD,      8'h5A, 16'h1234, 11'd126, 1'b0, NO_WORD},
            '{KIND_LOAD,      8'hC3, 16'h0000, 11'd2,   1'b0, NO_WORD},
            '{KIND_START,     8'hFF, 16'h0000, 11'd1,   1'b1, '{1'b0, 8'h00, PH_SENDING, 1'b0}},
            '{KIND_SLOT,      8'h00, 16'h0000, 11'd1,   1'b1, '{1'b1, BYTE_SOH, PH_SENDING, 1'b0}},
            '{KIND_SLOT,      8'h00, 16'h0000, 11'd1,   1'b1, '{1'b1, 8'h00, PH_SENDING, 1'b0}},
            '{KIND_SLOT,      8'h00, 16'h0000, 11'd1,   1'b1, '{1'b1, 8'hFF, PH_SENDING, 1'b0}},
            '{KIND_SLOT,      8'h00, 16'h0000, 11'd1,   1'b1, '{1'b1, 8'h00, PH_SENDING, 1'b0}},
            '{KIND_SLOT,      8'h00, 16'h0000, 11'd1,   1'b1, '{1'b1, 8'hFF, PH_SENDING, 1'b0}},
            '{KIND_SLOT,      8'h00, 16'h0000, 11'd126, 1'b0, NO_WORD},
            '{KIND_SLOT,      8'h00, 16'h0000, 11'd2,   1'b0, NO_WORD},
            '{KIND_LOAD,      8'h77, 16'h0000, 11'd1,   1'b1, '{1'b0, 8'h00, PH_AWAIT, 1'b0}},
            '{KIND_START,     8'h00, 16'hFFFF, 11'd1,   1'b1, '{1'b0, 8'h00, PH_AWAIT, 1'b0}},
            '{KIND_SLOT,      8'h00, 16'h0000, 11'd1,   1'b1, '{1'b0, 8'h00, PH_AWAIT, 1'b0}},
            '{KIND_TICK,      8'h00, 16'h0000, 11'd1,   1'b1, '{1'b0, 8'h00, PH_AWAIT, 1'b0}},
            '{KIND_REPLY,     8'h00, 16'h0000, 11'd1,   1'b1, '{1'b0, 8'h00, PH_BAD, 1'b0}},
            '{KIND_REPLY,     BYTE_NAK, 16'h0000, 11'd1, 1'b1, '{1'b0, 8'h00, PH_BAD, 1'b0}},
            '{KIND_TICK,      8'h00, 16'h0000, 11'd1,   1'b1, '{1'b0, 8'h00, PH_BAD, 1'b0}},
            '{KIND_UNUSED_HI, 8'hFF, 16'hFFFF, 11'd1,   1'b1, '{1'b0, 8'h00, PH_BAD, 1'b0}}
        };

        // timeout register per random phase: zero, then a small random value
        phase_timeout[0] = 16'd0;
        phase_timeout[1] = 16'($urandom_range(1, 12));

        // hold reset, then release
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed rows with the reset timeout value
        foreach (directed_rows[i]) begin
            for (int n = 0; n < directed_rows[i].reps; n++) begin
                put_word(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].blk,
                         directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // random phases: drain, reprogram the timeout, then run one exchange
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_for_results();
            write_timeout_reg(phase_timeout[ph]);
            // idle-phase noise before the exchange: ignored kinds only
            repeat ($urandom_range(1, 6)) begin
                put_word(noise_kind(KIND_SLOT, KIND_REPLY, KIND_TICK, KIND_REPLY),
                         8'($urandom), 16'($urandom), 1'b0, NO_WORD);
            end
            // drop ready for a long stretch while the frame keeps coming
            if (ph == 0) hold_request = 1'b1;
            run_exchange();
        end

        // long-packet header: STX, block byte, complement and the first
        // payload bytes, all from entries loaded earlier
        wait_for_results();
        case ($urandom_range(0, 2))
            0:       probe_blk = 16'h0001;
            1:       probe_blk = 16'hFFFF;
            default: probe_blk = 16'($urandom_range(2, 65534));
        endcase
        put_word(KIND_START, 8'($urandom), probe_blk, 1'b0, NO_WORD);
        repeat (PROBE_SLOTS) put_word(KIND_SLOT, 8'($urandom), 16'($urandom), 1'b0, NO_WORD);

        // drain and let the pipe settle before the verdict
        wait_for_results();
        if (expected_tx_words.size() != 0)
            report_mismatch("words never delivered", expected_tx_words.size(), 0);

        $display("covered %0d words in and %0d out over timeout settings 1000, 0, %0d",
                 words_in, words_out, phase_timeout[1]);
        $display("frames %0d plus a long header, acks %0d, naks %0d, bad %0d, timeouts %0d",
                 frames_sent, acks_seen, naks_seen, bad_seen, timeouts_seen);
        if (mismatches == 0) begin
            $display("[ymodem_packet_sender] OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[ymodem_packet_sender] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/ymps_pkg.sv
design/ymps_in_if.sv
design/ymps_out_if.sv
design/ymps_front.sv
design/ymps_queue.sv
design/ymps_ctrl.sv
design/ymps_emit.sv
design/ymodem_packet_sender.sv
tb/sv/tb_ymodem_packet_sender.sv
